FILE: hw/rtl/mfau_pkg.sv
`default_nettype none

package mfau_pkg;

  // Word format
  localparam int EXP_WIDTH  = 6;
  localparam int FRAC_WIDTH = 8;
  localparam int WORD_W     = 1 + EXP_WIDTH + FRAC_WIDTH;
  localparam int EXP_ALL    = (1 << EXP_WIDTH) - 1;
  localparam int EXP_BIAS   = (1 << (EXP_WIDTH - 1)) - 1;

  // Datapath sizes
  localparam int SIG_W  = FRAC_WIDTH + 1;             // significand with hidden one
  localparam int WIDE_W = 2 * SIG_W;                  // product / aligned sum width
  localparam int LEAD_W = $clog2(WIDE_W);             // leading-one position
  localparam int SHR_W  = $clog2(SIG_W + 1);          // denormal shift amount
  localparam int IEW    = EXP_WIDTH + $clog2(FRAC_WIDTH + 1) + 3;  // internal exponent

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [SIG_W-1:0]      sig;
    logic signed [IEW-1:0] exp;
  } unpacked_t;

  function automatic logic [EXP_WIDTH-1:0] exp_of(word_t w);
    return w[FRAC_WIDTH +: EXP_WIDTH];
  endfunction

  function automatic logic [FRAC_WIDTH-1:0] frac_of(word_t w);
    return w[FRAC_WIDTH-1:0];
  endfunction

  function automatic logic sign_of(word_t w);
    return w[WORD_W-1];
  endfunction

  function automatic logic is_nan(word_t w);
    return (exp_of(w) == EXP_WIDTH'(EXP_ALL)) && (frac_of(w) != '0);
  endfunction

  function automatic logic is_inf(word_t w);
    return (exp_of(w) == EXP_WIDTH'(EXP_ALL)) && (frac_of(w) == '0);
  endfunction

  function automatic logic is_zero(word_t w);
    return (exp_of(w) == '0) && (frac_of(w) == '0);
  endfunction

  function automatic word_t pack(logic sgn, logic [EXP_WIDTH-1:0] e, logic [FRAC_WIDTH-1:0] f);
    return {sgn, e, f};
  endfunction

  // Canonical NaN: positive, fraction one
  function automatic word_t canon_nan();
    return pack(1'b0, EXP_WIDTH'(EXP_ALL), FRAC_WIDTH'(1));
  endfunction

  function automatic word_t make_inf(logic sgn);
    return pack(sgn, EXP_WIDTH'(EXP_ALL), '0);
  endfunction

  // Finite word to significand and unbiased exponent
  function automatic unpacked_t unpack(word_t w);
    unpacked_t u;
    if (exp_of(w) == '0) begin
      u.sig = {1'b0, frac_of(w)};
      u.exp = IEW'(1 - EXP_BIAS);
    end else begin
      u.sig = {1'b1, frac_of(w)};
      u.exp = $signed({{(IEW-EXP_WIDTH){1'b0}}, exp_of(w)}) - IEW'(EXP_BIAS);
    end
    return u;
  endfunction

  // Normalize a nonzero significand (truncating) and encode, with
  // overflow to infinity and underflow to a denormal or zero.
  function automatic word_t encode(logic sgn, logic [WIDE_W-1:0] m,
                                   logic signed [IEW-1:0] e);
    logic [LEAD_W-1:0]     lead;
    logic [WIDE_W-1:0]     norm;
    logic [SIG_W-1:0]      mant;
    logic [SIG_W-1:0]      den;
    logic signed [IEW-1:0] x;
    logic signed [IEW-1:0] sh;
    word_t                 w;
    lead = '0;
    for (int i = 0; i < WIDE_W; i++) begin
      if (m[i]) lead = LEAD_W'(i);
    end
    norm = m << (LEAD_W'(WIDE_W - 1) - lead);
    mant = norm[WIDE_W-1 -: SIG_W];
    x    = e + $signed({{(IEW-LEAD_W){1'b0}}, lead}) + IEW'(EXP_BIAS + 1 - SIG_W);
    sh   = IEW'(1) - x;
    den  = '0;
    if (x >= IEW'(EXP_ALL)) begin
      w = make_inf(sgn);
    end else if (x >= IEW'(1)) begin
      w = pack(sgn, x[EXP_WIDTH-1:0], mant[FRAC_WIDTH-1:0]);
    end else begin
      if (sh < IEW'(SIG_W)) den = mant >> sh[SHR_W-1:0];
      w = pack(sgn, '0, den[FRAC_WIDTH-1:0]);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mfau_add.sv
`default_nettype none

module mfau_add (
  input  wire mfau_pkg::word_t a,
  input  wire mfau_pkg::word_t b,
  output mfau_pkg::word_t      sum
);
  import mfau_pkg::*;

  unpacked_t             ua, ub;
  logic [EXP_WIDTH-1:0]  xa, xb, d;
  logic                  a_small, far;
  logic [WIDE_W-1:0]     ma, mb, mag;
  logic signed [IEW-1:0] e;
  logic                  sa, sb, s;

  // Effective exponent codes (denormals sit at code one)
  assign ua = unpack(a);
  assign ub = unpack(b);
  assign xa = (exp_of(a) == '0) ? EXP_WIDTH'(1) : exp_of(a);
  assign xb = (exp_of(b) == '0) ? EXP_WIDTH'(1) : exp_of(b);
  assign a_small = xa < xb;
  assign d = a_small ? (xb - xa) : (xa - xb);
  assign far = {1'b0, d} > FRAC_WIDTH;
  assign sa = sign_of(a);
  assign sb = sign_of(b);

  // Align to the smaller exponent; a far operand collapses to one low bit
  always_comb begin
    if (a_small) begin
      ma = far ? WIDE_W'(1) : WIDE_W'(ua.sig);
      mb = far ? (WIDE_W'(ub.sig) << 1) : (WIDE_W'(ub.sig) << d);
      e  = far ? (ub.exp - IEW'(1)) : ua.exp;
    end else begin
      mb = far ? WIDE_W'(1) : WIDE_W'(ub.sig);
      ma = far ? (WIDE_W'(ua.sig) << 1) : (WIDE_W'(ua.sig) << d);
      e  = far ? (ua.exp - IEW'(1)) : ub.exp;
    end
  end

  // Sign-magnitude add
  always_comb begin
    if (sa == sb) begin
      mag = ma + mb;
      s   = sa;
    end else if (ma >= mb) begin
      mag = ma - mb;
      s   = sa;
    end else begin
      mag = mb - ma;
      s   = sb;
    end
  end

  // Special operands first
  always_comb begin
    priority if (is_nan(a) || is_nan(b)) begin
      sum = canon_nan();
    end else if (is_inf(a) && is_inf(b) && (sa != sb)) begin
      sum = canon_nan();
    end else if (is_inf(a)) begin
      sum = make_inf(sa);
    end else if (is_inf(b)) begin
      sum = make_inf(sb);
    end else if (is_zero(a) && is_zero(b)) begin
      sum = '0;
    end else if (is_zero(a)) begin
      sum = b;
    end else if (is_zero(b)) begin
      sum = a;
    end else if (mag == '0) begin
      sum = '0;
    end else begin
      sum = encode(s, mag, e);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mfau_mul.sv
`default_nettype none

module mfau_mul (
  input  wire mfau_pkg::word_t a,
  input  wire mfau_pkg::word_t b,
  output mfau_pkg::word_t      prod
);
  import mfau_pkg::*;

  unpacked_t             ua, ub;
  logic [WIDE_W-1:0]     m;
  logic signed [IEW-1:0] e;
  logic                  s;

  assign ua = unpack(a);
  assign ub = unpack(b);
  assign s  = sign_of(a) ^ sign_of(b);

  // Significand product and exponent sum
  assign m = WIDE_W'(ua.sig) * WIDE_W'(ub.sig);
  assign e = ua.exp + ub.exp - IEW'(FRAC_WIDTH);

  // Special operands first
  always_comb begin
    priority if (is_nan(a) || is_nan(b)) begin
      prod = canon_nan();
    end else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) begin
      prod = canon_nan();
    end else if (is_inf(a) || is_inf(b)) begin
      prod = make_inf(s);
    end else if (is_zero(a) || is_zero(b)) begin
      prod = pack(s, '0, '0);
    end else begin
      prod = encode(s, m, e);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/minifloat_add_mul_unit.sv
// A transaction passes through the input register, then add/multiply and normalize,
// then the result register.
// Throughput: one transaction per cycle; busy is never raised.
// Reset (rst, synchronous) clears the input and result valid flags; no
// result strobe follows reset until a new transaction. The receiver cannot stall.
`default_nettype none

module minifloat_add_mul_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            op,
  input  wire mfau_pkg::word_t operand_a,
  input  wire mfau_pkg::word_t operand_b,
  output logic                 done,
  output mfau_pkg::word_t      result
);
  import mfau_pkg::*;

  logic  in_valid;
  logic  in_op;
  word_t in_a, in_b;
  word_t sum, prod;

  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      in_op <= op;
      in_a  <= operand_a;
      in_b  <= operand_b;
    end
  end

  mfau_add u_add (
    .a   (in_a),
    .b   (in_b),
    .sum (sum)
  );

  mfau_mul u_mul (
    .a    (in_a),
    .b    (in_b),
    .prod (prod)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      result <= in_op ? prod : sum;
    end
  end

endmodule

`default_nettype wire
